### sv/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, constants and types of the sampler and its blend datapath.
// ----------------------------------------------------------------------------
package bts_pkg;

   // Texture store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int COL_W       = 8;
   localparam int ROW_W       = 8;
   localparam int ADDR_W      = COL_W + ROW_W;
   localparam int TEX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;

   // Configuration registers
   localparam int CFG_W       = 9;
   localparam int CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

   // Request kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Arithmetic widths
   localparam int CH_W        = 8;
   localparam int TEXEL_W     = 3 * CH_W;
   localparam int COORD_W     = 17;
   localparam int SCALED_W    = COORD_W + COL_W;
   localparam int FRAC_W      = 16;
   localparam int WEIGHT_W    = 33;
   localparam int ACC_W       = 40;
   localparam logic [COORD_W-1:0] ONE_Q16    = 17'h10000;
   localparam logic [ACC_W-1:0]   ROUND_HALF = 40'h00_8000_0000;

   // Request beat layout
   localparam int REQ_DATA_W  = 80;
   localparam int OFS_COL     = 0;
   localparam int OFS_ROW     = 8;
   localparam int OFS_TEXEL   = 16;
   localparam int OFS_U       = 40;
   localparam int OFS_V       = 57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_LAST
   } bts_state_type;

   // Control from the sequencer to the blend datapath
   typedef struct packed {
      logic weight_en;
      logic acc_en;
      logic acc_start;
   } bts_blend_ctl_type;

endpackage

### sv/bts_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear blend datapath
// Forms each texel weight as a product of the two axis weights, then
// accumulates texel times weight per channel and rounds half up.
// ----------------------------------------------------------------------------
module bts_blend (
   input  logic                          clock,
   input  bts_pkg::bts_blend_ctl_type    ctl,
   input  logic [bts_pkg::TEXEL_W-1:0]   texel,
   input  logic [bts_pkg::COORD_W-1:0]   wu,
   input  logic [bts_pkg::COORD_W-1:0]   wv,
   output logic [bts_pkg::TEXEL_W-1:0]   rgb
);

   logic [bts_pkg::WEIGHT_W-1:0]  weight_ff;
   logic [bts_pkg::WEIGHT_W-1:0]  weight_in;
   logic [2*bts_pkg::COORD_W-1:0] weight_full;
   logic [bts_pkg::ACC_W-1:0]     acc_ff  [3];
   logic [bts_pkg::ACC_W-1:0]     acc_in  [3];
   logic [bts_pkg::ACC_W-1:0]     sum     [3];

   // Weight of the texel being read: at most 2^32
   assign weight_full = (2*bts_pkg::COORD_W)'(wu) * (2*bts_pkg::COORD_W)'(wv);
   assign weight_in   = weight_full[bts_pkg::WEIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.weight_en) begin
         weight_ff <= weight_in;
      end
   end

   // One lane per channel: add texel times weight, restart on the first texel
   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [bts_pkg::ACC_W-1:0] base;
      logic [bts_pkg::ACC_W-1:0] prod;

      assign base = ctl.acc_start ? bts_pkg::ROUND_HALF : acc_ff[c];
      assign prod = bts_pkg::ACC_W'(texel[c*bts_pkg::CH_W +: bts_pkg::CH_W])
                  * bts_pkg::ACC_W'(weight_ff);
      assign sum[c]    = base + prod;
      assign acc_in[c] = sum[c];
      assign rgb[c*bts_pkg::CH_W +: bts_pkg::CH_W] =
         sum[c][bts_pkg::ACC_W-1 -: bts_pkg::CH_W];

      always_ff @(posedge clock) begin
         if (ctl.acc_en) begin
            acc_ff[c] <= acc_in[c];
         end
      end
   end

endmodule

### sv/bilinear_texture_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// Holds one RGB texture and returns the bilinear blend at a Q1.16 coordinate.
// ----------------------------------------------------------------------------
// A write beat (tuser = 0) stores one texel and gives no result. A sample
// beat (tuser = 1) keeps the request side closed from the split state
// through the final state. The coordinates are scaled as the beat is taken.
// The split state splits them into index and fraction. Four read states
// read the single-ported 65536 x 24 texel memory. A final state completes
// the blend and loads the result register. The final state repeats for as
// long as an earlier result still waits unaccepted in the output register.
// The next beat is accepted as soon as the sequencer is back in idle, even
// while a result still waits in the output register. Texels that were never
// written read as arbitrary values.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration
   input  logic                            csr_we,
   input  logic [bts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bts_pkg::CFG_W-1:0]       csr_wdata,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // write_col, write_row, texel_red, texel_green, texel_blue, coord_u,
   // coord_v, zero pad
   input  logic [bts_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic                            req_tuser,
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_red, out_green, out_blue
   output logic [bts_pkg::TEXEL_W-1:0]     rsp_tdata
);

   bts_pkg::bts_state_type state_ff, state_in;

   logic [bts_pkg::CFG_W-1:0]    cfg_w_ff, cfg_w_in;
   logic [bts_pkg::CFG_W-1:0]    cfg_h_ff, cfg_h_in;
   logic [bts_pkg::COL_W-1:0]    wm1_ff, wm1_in;
   logic [bts_pkg::ROW_W-1:0]    hm1_ff, hm1_in;
   logic [bts_pkg::SCALED_W-1:0] xu_ff, xu_in;
   logic [bts_pkg::SCALED_W-1:0] xv_ff, xv_in;
   logic [bts_pkg::COL_W-1:0]    col_ff, col_in;
   logic [bts_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [bts_pkg::COORD_W-1:0]  fu_ff, fu_in;
   logic [bts_pkg::COORD_W-1:0]  fv_ff, fv_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bts_pkg::TEXEL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [bts_pkg::TEXEL_W-1:0]  rdata_ff;

   logic [bts_pkg::TEXEL_W-1:0]  tex_mem [bts_pkg::TEX_DEPTH];

   logic                         req_accept;
   logic                         rsp_free;
   logic                         rsp_load;
   logic                         mem_we;
   logic                         mem_re;
   logic [bts_pkg::ADDR_W-1:0]   mem_addr;
   logic                         rd_col_step;
   logic                         rd_row_step;
   logic                         sel_fu;
   logic                         sel_fv;
   logic [bts_pkg::COORD_W-1:0]  wu;
   logic [bts_pkg::COORD_W-1:0]  wv;
   logic [bts_pkg::COORD_W-1:0]  u_sat;
   logic [bts_pkg::COORD_W-1:0]  v_sat;
   logic [bts_pkg::CFG_W-1:0]    iu;
   logic [bts_pkg::CFG_W-1:0]    jv;
   logic [bts_pkg::TEXEL_W-1:0]  blend_rgb;
   bts_pkg::bts_blend_ctl_type   blend_ctl;

   // Request fields
   logic [bts_pkg::COL_W-1:0]    f_col;
   logic [bts_pkg::ROW_W-1:0]    f_row;
   logic [bts_pkg::TEXEL_W-1:0]  f_texel;
   logic [bts_pkg::COORD_W-1:0]  f_u;
   logic [bts_pkg::COORD_W-1:0]  f_v;

   assign f_col   = req_tdata[bts_pkg::OFS_COL   +: bts_pkg::COL_W];
   assign f_row   = req_tdata[bts_pkg::OFS_ROW   +: bts_pkg::ROW_W];
   assign f_texel = req_tdata[bts_pkg::OFS_TEXEL +: bts_pkg::TEXEL_W];
   assign f_u     = req_tdata[bts_pkg::OFS_U     +: bts_pkg::COORD_W];
   assign f_v     = req_tdata[bts_pkg::OFS_V     +: bts_pkg::COORD_W];

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes
   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      if (csr_we) begin
         case (csr_index)
            bts_pkg::CSR_TEX_WIDTH:  cfg_w_in = csr_wdata;
            bts_pkg::CSR_TEX_HEIGHT: cfg_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp sizes into range and take size minus one
   always_comb begin
      if (cfg_w_ff < bts_pkg::CFG_W'(2)) begin
         wm1_in = bts_pkg::COL_W'(1);
      end else if (cfg_w_ff > bts_pkg::CFG_W'(bts_pkg::MAX_WIDTH)) begin
         wm1_in = bts_pkg::COL_W'(bts_pkg::MAX_WIDTH - 1);
      end else begin
         wm1_in = bts_pkg::COL_W'(cfg_w_ff - bts_pkg::CFG_W'(1));
      end
      if (cfg_h_ff < bts_pkg::CFG_W'(2)) begin
         hm1_in = bts_pkg::ROW_W'(1);
      end else if (cfg_h_ff > bts_pkg::CFG_W'(bts_pkg::MAX_HEIGHT)) begin
         hm1_in = bts_pkg::ROW_W'(bts_pkg::MAX_HEIGHT - 1);
      end else begin
         hm1_in = bts_pkg::ROW_W'(cfg_h_ff - bts_pkg::CFG_W'(1));
      end
   end

   // Saturate coordinates at one and scale by size minus one
   assign u_sat = (f_u > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : f_u;
   assign v_sat = (f_v > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : f_v;
   assign xu_in = bts_pkg::SCALED_W'(u_sat) * bts_pkg::SCALED_W'(wm1_in);
   assign xv_in = bts_pkg::SCALED_W'(v_sat) * bts_pkg::SCALED_W'(hm1_in);

   // Split into index and fraction; pull the last index back by one
   assign iu = xu_ff[bts_pkg::SCALED_W-1:bts_pkg::FRAC_W];
   assign jv = xv_ff[bts_pkg::SCALED_W-1:bts_pkg::FRAC_W];

   always_comb begin
      if (iu >= bts_pkg::CFG_W'(wm1_ff)) begin
         col_in = wm1_ff - bts_pkg::COL_W'(1);
         fu_in  = bts_pkg::ONE_Q16;
      end else begin
         col_in = iu[bts_pkg::COL_W-1:0];
         fu_in  = bts_pkg::COORD_W'(xu_ff[bts_pkg::FRAC_W-1:0]);
      end
      if (jv >= bts_pkg::CFG_W'(hm1_ff)) begin
         row_in = hm1_ff - bts_pkg::ROW_W'(1);
         fv_in  = bts_pkg::ONE_Q16;
      end else begin
         row_in = jv[bts_pkg::ROW_W-1:0];
         fv_in  = bts_pkg::COORD_W'(xv_ff[bts_pkg::FRAC_W-1:0]);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bts_pkg::ST_IDLE: begin
            if (req_accept && (req_tuser == bts_pkg::KIND_SAMPLE)) begin
               state_in = bts_pkg::ST_SPLIT;
            end
         end
         bts_pkg::ST_SPLIT: state_in = bts_pkg::ST_RD0;
         bts_pkg::ST_RD0:   state_in = bts_pkg::ST_RD1;
         bts_pkg::ST_RD1:   state_in = bts_pkg::ST_RD2;
         bts_pkg::ST_RD2:   state_in = bts_pkg::ST_RD3;
         bts_pkg::ST_RD3:   state_in = bts_pkg::ST_LAST;
         bts_pkg::ST_LAST: begin
            if (rsp_free) begin
               state_in = bts_pkg::ST_IDLE;
            end
         end
         default: state_in = bts_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready          = 1'b0;
      mem_re              = 1'b0;
      rd_col_step         = 1'b0;
      rd_row_step         = 1'b0;
      rsp_load            = 1'b0;
      blend_ctl.weight_en = 1'b0;
      blend_ctl.acc_en    = 1'b0;
      blend_ctl.acc_start = 1'b0;
      case (state_ff)
         bts_pkg::ST_IDLE: req_tready = 1'b1;
         bts_pkg::ST_SPLIT: ;
         bts_pkg::ST_RD0: begin
            mem_re              = 1'b1;
            blend_ctl.weight_en = 1'b1;
         end
         bts_pkg::ST_RD1: begin
            mem_re              = 1'b1;
            rd_col_step         = 1'b1;
            blend_ctl.weight_en = 1'b1;
            blend_ctl.acc_en    = 1'b1;
            blend_ctl.acc_start = 1'b1;
         end
         bts_pkg::ST_RD2: begin
            mem_re              = 1'b1;
            rd_row_step         = 1'b1;
            blend_ctl.weight_en = 1'b1;
            blend_ctl.acc_en    = 1'b1;
         end
         bts_pkg::ST_RD3: begin
            mem_re              = 1'b1;
            rd_col_step         = 1'b1;
            rd_row_step         = 1'b1;
            blend_ctl.weight_en = 1'b1;
            blend_ctl.acc_en    = 1'b1;
         end
         bts_pkg::ST_LAST: begin
            rsp_load         = rsp_free;
            blend_ctl.acc_en = rsp_free;
         end
         default: ;
      endcase
   end

   // Axis weights of the texel being read
   assign sel_fu = rd_col_step;
   assign sel_fv = rd_row_step;
   assign wu = sel_fu ? fu_ff : (bts_pkg::ONE_Q16 - fu_ff);
   assign wv = sel_fv ? fv_ff : (bts_pkg::ONE_Q16 - fv_ff);

   // Single memory port: write in idle, read the four neighbors otherwise
   assign mem_we = req_accept && (req_tuser == bts_pkg::KIND_WRITE);
   always_comb begin
      if (state_ff == bts_pkg::ST_IDLE) begin
         mem_addr = {f_col, f_row};
      end else begin
         mem_addr = {col_ff + bts_pkg::COL_W'(rd_col_step),
                     row_ff + bts_pkg::ROW_W'(rd_row_step)};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem[mem_addr] <= f_texel;
      end
      if (mem_re) begin
         rdata_ff <= tex_mem[mem_addr];
      end
   end

   bts_blend u_blend (
      .clock (clock),
      .ctl   (blend_ctl),
      .texel (rdata_ff),
      .wu    (wu),
      .wv    (wv),
      .rgb   (blend_rgb)
   );

   // Output register
   always_comb begin
      rsp_data_in  = rsp_load ? blend_rgb : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bts_pkg::ST_IDLE;
         cfg_w_ff     <= bts_pkg::SIZE_RESET;
         cfg_h_ff     <= bts_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         xu_ff  <= xu_in;
         xv_ff  <= xv_in;
         wm1_ff <= wm1_in;
         hm1_ff <= hm1_in;
      end
      if (state_ff == bts_pkg::ST_SPLIT) begin
         col_ff <= col_in;
         row_ff <= row_in;
         fu_ff  <= fu_in;
         fv_ff  <= fv_in;
      end
   end

endmodule

### sv/bts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler port checker
// Watches the sampler's ports for sequencing and output register slips.
// ----------------------------------------------------------------------------
module bts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bts_pkg::TEXEL_W-1:0]     rsp_tdata
);

   // Clear the result register on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Drop the ready after a sample beat: one sample is in work at a time
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bts_pkg::KIND_SAMPLE)
      |=> !req_tready)
      else $error("request taken while a sample is in work");

   // A texel write beat never makes a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bts_pkg::KIND_WRITE)
      && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result made by a texel write");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Loads texels and samples the texture at directed and random Q1.16
// coordinates over a range of texture sizes. A scoreboard keeps its own copy
// of the texel store and the size registers and predicts each blended
// result. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import bts_pkg::*;

   localparam int ITEM_TARGET   = 850;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 4000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   // Predicts blended texels and checks them in order
   class blend_checker;
      bit [TEXEL_W-1:0] texels [TEX_DEPTH];
      bit               written [TEX_DEPTH];
      bit [CFG_W-1:0]   width_reg  = SIZE_RESET;
      bit [CFG_W-1:0]   height_reg = SIZE_RESET;
      bit [TEXEL_W-1:0] blend_queue [$];
      int               errors  = 0;

      task report(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("[%0t] error: %s: expected %0h, got %0h", $time, what, want, got);
      endtask

      function void set_register(bit [CSR_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
         if (idx == CSR_TEX_WIDTH) width_reg = value;
         else if (idx == CSR_TEX_HEIGHT) height_reg = value;
      endfunction

      // Sizes below two act as two, sizes above the store act as the store
      function bit [CFG_W-1:0] clamp_size(bit [CFG_W-1:0] value, int limit);
         if (value < 2) return CFG_W'(2);
         if (value > limit) return CFG_W'(limit);
         return value;
      endfunction

      // Scale by size minus one; a coordinate of one lands on the last pair
      // of texels with a full fraction
      function void split_coord(bit [COORD_W-1:0] c, bit [CFG_W-1:0] size,
                                output bit [CFG_W-1:0] idx,
                                output bit [COORD_W-1:0] frac);
         bit [SCALED_W-1:0] x;
         if (c > ONE_Q16) c = ONE_Q16;
         x = SCALED_W'(c) * SCALED_W'(size - CFG_W'(1));
         if (x[SCALED_W-1:FRAC_W] >= size - CFG_W'(1)) begin
            idx  = size - CFG_W'(2);
            frac = ONE_Q16;
         end else begin
            idx  = x[SCALED_W-1:FRAC_W];
            frac = COORD_W'(x[FRAC_W-1:0]);
         end
      endfunction

      function void locate(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v,
                           output bit [CFG_W-1:0] col, output bit [CFG_W-1:0] row,
                           output bit [COORD_W-1:0] fu, output bit [COORD_W-1:0] fv);
         split_coord(u, clamp_size(width_reg, MAX_WIDTH), col, fu);
         split_coord(v, clamp_size(height_reg, MAX_HEIGHT), row, fv);
      endfunction

      function bit is_written(int col, int row);
         return written[col * MAX_HEIGHT + row];
      endfunction

      function bit [TEXEL_W-1:0] blend_at(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v);
         bit [CFG_W-1:0]    col, row;
         bit [COORD_W-1:0]  fu, fv;
         bit [TEXEL_W-1:0]  t [4];
         bit [WEIGHT_W-1:0] wt [4];
         bit [ACC_W-1:0]    acc;
         bit [TEXEL_W-1:0]  rgb;
         locate(u, v, col, row, fu, fv);
         t[0] = texels[col * MAX_HEIGHT + row];
         t[1] = texels[(col + 1) * MAX_HEIGHT + row];
         t[2] = texels[col * MAX_HEIGHT + row + 1];
         t[3] = texels[(col + 1) * MAX_HEIGHT + row + 1];
         wt[0] = WEIGHT_W'(ONE_Q16 - fu) * WEIGHT_W'(ONE_Q16 - fv);
         wt[1] = WEIGHT_W'(fu) * WEIGHT_W'(ONE_Q16 - fv);
         wt[2] = WEIGHT_W'(ONE_Q16 - fu) * WEIGHT_W'(fv);
         wt[3] = WEIGHT_W'(fu) * WEIGHT_W'(fv);
         // Weights sum to 2^32; add half and keep the top byte
         for (int ch = 0; ch < 3; ch++) begin
            acc = ROUND_HALF;
            for (int k = 0; k < 4; k++)
               acc += ACC_W'(t[k][CH_W*ch +: CH_W]) * ACC_W'(wt[k]);
            rgb[CH_W*ch +: CH_W] = acc[ACC_W-1 -: CH_W];
         end
         return rgb;
      endfunction

      // Apply a write to the store, or queue the blend a sample will return
      function void note_request(logic kind, logic [REQ_DATA_W-1:0] d);
         int addr;
         if (kind == KIND_WRITE) begin
            addr = d[OFS_COL +: COL_W] * MAX_HEIGHT + d[OFS_ROW +: ROW_W];
            texels[addr]  = d[OFS_TEXEL +: TEXEL_W];
            written[addr] = 1'b1;
         end else begin
            blend_queue.push_back(blend_at(d[OFS_U +: COORD_W], d[OFS_V +: COORD_W]));
         end
      endfunction

      task check_result(logic [TEXEL_W-1:0] got);
         bit [TEXEL_W-1:0] want;
         string            chan;
         if (blend_queue.size() == 0) begin
            report("result beat with nothing pending", 0, 32'(got));
            return;
         end
         want = blend_queue.pop_front();
         for (int ch = 0; ch < 3; ch++) begin
            chan = (ch == 0) ? "red" : (ch == 1) ? "green" : "blue";
            if (got[CH_W*ch +: CH_W] !== want[CH_W*ch +: CH_W])
               report({chan, " channel"}, 32'(want[CH_W*ch +: CH_W]),
                      32'(got[CH_W*ch +: CH_W]));
         end
      endtask

      function int pending();
         return blend_queue.size();
      endfunction

      task close_out();
         if (blend_queue.size() != 0)
            report("results never returned", blend_queue.size(), 0);
      endtask
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index  = CSR_TEX_WIDTH;
   logic [CFG_W-1:0]         csr_wdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                     req_tuser  = KIND_WRITE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [TEXEL_W-1:0]       rsp_tdata;

   blend_checker   sb = new();
   int             beats_sent  = 0;
   int             burst_left  = 0;
   int             stall_count = 0;
   int             rx_left     = 0;
   rx_pattern_type rx_pattern  = RX_OPEN;

   bilinear_texture_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check result beats and pick the next receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_pattern)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
         RX_PERIODIC: rsp_tready <= (rx_left % 4) != 0;
         default:     rsp_tready <= 1'b1;
      endcase
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count > STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Send one request beat; open a random gap when the burst runs out
   task automatic push_beat(logic kind, logic [REQ_DATA_W-1:0] d);
      int gap;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, d);
      beats_sent++;
      burst_left--;
   endtask

   // Drain all pending results, then let the sequencer finish
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(bit [CFG_W-1:0] w, bit [CFG_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_TEX_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.set_register(CSR_TEX_WIDTH, w);
      csr_index <= CSR_TEX_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.set_register(CSR_TEX_HEIGHT, h);
      csr_we <= 1'b0;
   endtask

   task automatic write_texel(bit [COL_W-1:0] col, bit [ROW_W-1:0] row,
                              bit [TEXEL_W-1:0] rgb);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[OFS_COL +: COL_W]     = col;
      d[OFS_ROW +: ROW_W]     = row;
      d[OFS_TEXEL +: TEXEL_W] = rgb;
      d[OFS_U +: COORD_W]     = COORD_W'($urandom);
      d[OFS_V +: COORD_W]     = COORD_W'($urandom);
      push_beat(KIND_WRITE, d);
   endtask

   // Load any missing neighbor texel first, then sample
   task automatic sample_at(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v);
      bit [CFG_W-1:0]        col, row;
      bit [COORD_W-1:0]      fu, fv;
      logic [REQ_DATA_W-1:0] d;
      sb.locate(u, v, col, row, fu, fv);
      for (int dc = 0; dc < 2; dc++)
         for (int dr = 0; dr < 2; dr++)
            if (!sb.is_written(col + dc, row + dr))
               write_texel(COL_W'(col + dc), ROW_W'(row + dr), TEXEL_W'($urandom));
      d = '0;
      d[OFS_U-1:0]        = OFS_U'({$urandom, $urandom});
      d[OFS_U +: COORD_W] = u;
      d[OFS_V +: COORD_W] = v;
      push_beat(KIND_SAMPLE, d);
   endtask

   function automatic bit [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ONE_Q16;
         2:       return COORD_W'($urandom_range(ONE_Q16 + 1, 2 * ONE_Q16 - 1));
         3:       return COORD_W'(ONE_Q16 - $urandom_range(1, 300));
         default: return COORD_W'($urandom_range(0, ONE_Q16 - 1));
      endcase
   endfunction

   function automatic bit [CFG_W-1:0] pick_size();
      bit [CFG_W-1:0] edges [7] = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd257, 9'd511};
      case ($urandom_range(0, 4))
         0:       return CFG_W'($urandom_range(0, 511));
         1:       return edges[$urandom_range(0, 6)];
         default: return CFG_W'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      bit [CFG_W-1:0] w, h;
      int             phase, phase_end, pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Full-size texture: corner texels with extreme channels
      write_texel(0, 0, 24'hFFFFFF);
      write_texel(1, 0, 24'h000000);
      write_texel(0, 1, 24'hFF00FF);
      write_texel(1, 1, 24'h00FF00);
      write_texel(254, 254, 24'h0000FF);
      write_texel(255, 254, 24'hFFFFFF);
      write_texel(254, 255, 24'h000000);
      write_texel(255, 255, 24'hFF00FF);
      // Origin, smallest step, coordinate of one, saturation above one
      sample_at(0, 0);
      sample_at(1, 1);
      sample_at(ONE_Q16, ONE_Q16);
      sample_at(COORD_W'(2 * ONE_Q16 - 1), COORD_W'(2 * ONE_Q16 - 1));
      sample_at(ONE_Q16, 0);
      sample_at(0, ONE_Q16);

      // Random phases, each under its own texture size
      phase = 0;
      while (beats_sent < ITEM_TARGET) begin
         settle();
         case (phase)
            0:       begin w = 2;   h = 2;   end
            1:       begin w = 0;   h = 1;   end
            2:       begin w = 511; h = 257; end
            3:       begin w = 256; h = 3;   end
            default: begin w = pick_size(); h = pick_size(); end
         endcase
         write_sizes(w, h);
         phase_end = beats_sent + $urandom_range(60, 140);
         if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
         while (beats_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               write_texel(COL_W'($urandom), ROW_W'($urandom), TEXEL_W'($urandom));
            else if (pick == 1)
               write_texel(COL_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 15)),
                           TEXEL_W'($urandom));
            else
               sample_at(pick_coord(), pick_coord());
         end
         phase++;
      end

      settle();
      sb.close_out();
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
